// File: design/crb_pkg.sv
// Shared types and constants for the cubic root bisection block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package crb_pkg;

	localparam int COEF_W   = 32;
	localparam int CFG_W    = 16;
	localparam int ROOT_W   = 32;
	localparam int LEFT_W   = 8;
	localparam int STEP_W   = 6;

	localparam logic [1:0] REG_TOLERANCE  = 2'd0;
	localparam logic [1:0] REG_SCAN_START = 2'd1;
	localparam logic [1:0] REG_SCAN_END   = 2'd2;
	localparam logic [1:0] REG_ITER_LIMIT = 2'd3;

	localparam logic [15:0] RST_TOLERANCE  = 16'd66;
	localparam logic [7:0]  RST_SCAN_START = 8'h9C;
	localparam logic [7:0]  RST_SCAN_END   = 8'h64;
	localparam logic [5:0]  RST_ITER_LIMIT = 6'd40;

	typedef enum logic [1:0] {
		OUT_CONVERGED = 2'd0,
		OUT_NO_SIGN   = 2'd1,
		OUT_LIMIT     = 2'd2
	} outcome_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] d;
	} coef_set_t;

	typedef struct packed {
		coef_set_t coef;
		logic      empty_range;
	} job_t;

	typedef struct packed {
		logic [15:0]       tolerance;
		logic signed [7:0] scan_start;
		logic signed [7:0] scan_end;
		logic [5:0]        iter_limit;
	} cfg_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} sign_t;

	typedef struct packed {
		logic signed [ROOT_W-1:0] root;
		logic signed [LEFT_W-1:0] bracket;
		logic [STEP_W-1:0]        steps;
		outcome_t                 outcome;
	} result_t;

endpackage

// File: design/cubic_root_bisection.sv
// Top level of the cubic root bisection block: configuration registers,
// front end, queue and sequencer. Depends on crb_pkg and all crb_ modules.
//
// Input channel: in_valid / in_stall carries the four Q16.16 coefficients
// of a*x^3 + b*x^2 + c*x + d. A transaction is taken when in_valid is high
// and in_stall is low; a two-entry queue holds up to two waiting items.
// Output channel: out_valid / out_stall carries one result per item: the
// last Q8.24 midpoint, the left integer of the bracket, the step count and
// the outcome (converged, no sign change, limit reached).
// Each polynomial evaluation runs on the shared 32x32 multiplier; with the
// default widths there are NL = 5 accumulator limbs and NXL = 1 argument
// limb. An item costs one evaluation per integer scanned plus one, and one
// per bisection step: with the reset configuration up to 241 evaluations.
// Items are worked one at a time in order.
// The configuration port writes tolerance, scan start, scan end and the
// step limit; write it only while the block is idle.
// Reset clears the queue and the sequencer and loads the default
// configuration. A stalled result stays on the output while the next item
// is already being worked; that item then waits for the output register.
`timescale 1ns / 1ps
module cubic_root_bisection #(
	parameter int X_FRAC_BITS = 24,
	parameter int EVAL_WIDTH  = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] coef_cubic,
	input  logic signed [31:0] coef_square,
	input  logic signed [31:0] coef_linear,
	input  logic signed [31:0] coef_constant,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] root_value,
	output logic signed [7:0]  bracket_left,
	output logic [5:0]         step_count,
	output logic [1:0]         outcome,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import crb_pkg::*;

	cfg_t      cfg_q;
	coef_set_t coef;
	job_t      push_data;
	job_t      pop_data;
	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      q_valid;
	result_t   res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance  <= RST_TOLERANCE;
			cfg_q.scan_start <= RST_SCAN_START;
			cfg_q.scan_end   <= RST_SCAN_END;
			cfg_q.iter_limit <= RST_ITER_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TOLERANCE:  cfg_q.tolerance  <= cfg_data;
				REG_SCAN_START: cfg_q.scan_start <= cfg_data[7:0];
				REG_SCAN_END:   cfg_q.scan_end   <= cfg_data[7:0];
				REG_ITER_LIMIT: cfg_q.iter_limit <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign coef = '{a: coef_cubic, b: coef_square, c: coef_linear, d: coef_constant};

	crb_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.coef     (coef),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	crb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (pop_data)
	);

	crb_back #(.XF(X_FRAC_BITS), .EW(EVAL_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (pop_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign root_value   = res.root;
	assign bracket_left = res.bracket;
	assign step_count   = res.steps;
	assign outcome      = res.outcome;

endmodule

// File: design/crb_front.sv
// Front end: accepts coefficient transactions and flags empty scan ranges.
// Depends on crb_pkg.
`timescale 1ns / 1ps
module crb_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  crb_pkg::coef_set_t coef,
	input  crb_pkg::cfg_t     cfg,
	input  logic              q_full,
	output logic              q_push,
	output crb_pkg::job_t     q_data
);
	import crb_pkg::*;

	assign in_stall           = q_full;
	assign q_push             = in_valid & ~q_full;
	assign q_data.coef        = coef;
	assign q_data.empty_range = !(cfg.scan_start < cfg.scan_end);

endmodule

// File: design/crb_fifo.sv
// Two-entry queue between the front end and the sequencer.
// Depends on crb_pkg.
`timescale 1ns / 1ps
module crb_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  crb_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output crb_pkg::job_t pop_data
);
	import crb_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: design/crb_eval.sv
// Polynomial evaluator: exact Horner form on one shared 32x32 multiplier,
// then saturation, sign and tolerance test. Depends on crb_pkg.
`timescale 1ns / 1ps
module crb_eval #(
	parameter int XF = 24,
	parameter int EW = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [8+XF-1:0]   x,
	input  crb_pkg::coef_set_t       coef,
	input  logic [15:0]              tol,
	output logic                     done,
	output crb_pkg::sign_t           sign,
	output logic                     conv
);
	import crb_pkg::*;

	localparam int XW      = 8 + XF;
	localparam int NXL     = (XW + 31) / 32;
	localparam int AW_NEED = 32 + 3 * XW + 2;
	localparam int AW_RAW  = (AW_NEED > EW) ? AW_NEED : EW;
	localparam int NL      = (AW_RAW + 31) / 32;
	localparam int AW      = NL * 32;
	localparam int LIW     = $clog2(NL);
	localparam int XJW     = (NXL > 1) ? $clog2(NXL) : 1;
	localparam int SHW     = $clog2(NL + NXL);

	typedef enum logic [2:0] {
		S_IDLE, S_MAG, S_MUL, S_DRAIN, S_SGN, S_ADD, S_CHECK
	} state_t;

	state_t                state_q;
	logic signed [AW-1:0]  acc_q;
	logic [AW-1:0]         mag_q;
	logic [AW-1:0]         prod_q;
	logic signed [XW-1:0]  x_q;
	logic [XW-1:0]         xmag_q;
	logic                  neg_q;
	logic [1:0]            k_q;
	logic [LIW-1:0]        li_q;
	logic [XJW-1:0]        xj_q;
	logic [63:0]           pp_q;
	logic [SHW-1:0]        psh_q;
	logic                  pv_q;

	logic [NXL*32-1:0]     xpad;
	logic [AW+63:0]        pp_wide;
	logic [AW-1:0]         pp_add;
	logic signed [AW-1:0]  term;
	logic                  fits;
	logic signed [EW-1:0]  sat;
	logic signed [EW-1:0]  fsh;
	logic signed [EW-1:0]  tol_w;
	logic                  last_pair;

	always_comb begin
		xpad      = (NXL*32)'(xmag_q);
		pp_wide   = (AW+64)'(pp_q) << {psh_q, 5'b0};
		pp_add    = pp_wide[AW-1:0];
		last_pair = (li_q == LIW'(NL-1)) && (xj_q == XJW'(NXL-1));
		case (k_q)
			2'd1:    term = AW'(coef.b) <<< XF;
			2'd2:    term = AW'(coef.c) <<< (2*XF);
			default: term = AW'(coef.d) <<< (3*XF);
		endcase
		fits  = (&acc_q[AW-1:EW-1]) | ~(|acc_q[AW-1:EW-1]);
		sat   = fits ? acc_q[EW-1:0] : {acc_q[AW-1], {(EW-1){~acc_q[AW-1]}}};
		fsh   = sat >>> (3*XF);
		tol_w = $signed(EW'(tol));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			pv_q    <= 1'b0;
			sign    <= '0;
			conv    <= 1'b0;
			k_q     <= 2'd1;
			li_q    <= '0;
			xj_q    <= '0;
		end else begin
			done <= (state_q == S_CHECK);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						acc_q   <= AW'(coef.a);
						x_q     <= x;
						k_q     <= 2'd1;
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					neg_q   <= acc_q[AW-1] ^ x_q[XW-1];
					mag_q   <= acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
					xmag_q  <= x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
					prod_q  <= '0;
					li_q    <= '0;
					xj_q    <= '0;
					pv_q    <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					pp_q  <= mag_q[li_q*32 +: 32] * xpad[xj_q*32 +: 32];
					psh_q <= SHW'(li_q) + SHW'(xj_q);
					pv_q  <= 1'b1;
					if (pv_q) begin
						prod_q <= prod_q + pp_add;
					end
					if (li_q == LIW'(NL-1)) begin
						li_q <= '0;
						xj_q <= xj_q + XJW'(1);
					end else begin
						li_q <= li_q + LIW'(1);
					end
					if (last_pair) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					prod_q  <= prod_q + pp_add;
					pv_q    <= 1'b0;
					state_q <= S_SGN;
				end
				S_SGN: begin
					acc_q   <= neg_q ? $signed(-prod_q) : $signed(prod_q);
					state_q <= S_ADD;
				end
				S_ADD: begin
					acc_q <= acc_q + term;
					if (k_q == 2'd3) begin
						state_q <= S_CHECK;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_MAG;
					end
				end
				S_CHECK: begin
					sign.neg  <= acc_q[AW-1];
					sign.zero <= ~(|acc_q);
					conv      <= (fsh <= tol_w) && (fsh >= -tol_w);
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/crb_back.sv
// Sequencer: unit-interval scan, then bisection, with the result register.
// Depends on crb_pkg and crb_eval.
`timescale 1ns / 1ps
module crb_back #(
	parameter int XF = 24,
	parameter int EW = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  crb_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  crb_pkg::job_t     q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output crb_pkg::result_t  res
);
	import crb_pkg::*;

	localparam int XW = 8 + XF;

	typedef enum logic [2:0] {
		B_IDLE, B_WAIT_LO, B_WAIT_HI, B_BISECT, B_WAIT_MID, B_FINISH
	} state_t;

	state_t               state_q;
	coef_set_t            coef_q;
	logic signed [7:0]    left_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] lo_q;
	logic signed [XW-1:0] hi_q;
	logic signed [XW-1:0] mid_q;
	sign_t                slo_q;
	sign_t                shi_q;
	logic [STEP_W-1:0]    steps_q;
	result_t              fin_q;
	logic                 start_q;

	logic                 ev_done;
	sign_t                ev_sign;
	logic                 ev_conv;
	logic signed [9:0]    left_p1;
	logic signed [9:0]    left_p2;
	logic signed [XW:0]   span;
	logic signed [XW-1:0] mid;
	logic [STEP_W-1:0]    steps_nx;
	logic                 opposite;
	logic signed [63:0]   mid64;
	logic                 res_load;

	crb_eval #(.XF(XF), .EW(EW)) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.x      (x_q),
		.coef   (coef_q),
		.tol    (cfg.tolerance),
		.done   (ev_done),
		.sign   (ev_sign),
		.conv   (ev_conv)
	);

	always_comb begin
		left_p1  = 10'(left_q) + 10'sd1;
		left_p2  = 10'(left_q) + 10'sd2;
		span     = (XW+1)'(hi_q) - (XW+1)'(lo_q);
		mid      = lo_q + XW'(span >>> 1);
		steps_nx = steps_q + STEP_W'(1);
		opposite = !slo_q.zero && !ev_sign.zero && (slo_q.neg != ev_sign.neg);
		mid64    = 64'(mid_q);
	end

	assign q_pop    = (state_q == B_IDLE) && q_valid;
	assign res_load = (state_q == B_FINISH) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			start_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					start_q <= q_valid && !q_data.empty_range;
					if (q_valid) begin
						coef_q <= q_data.coef;
						left_q <= cfg.scan_start;
						x_q    <= XW'(cfg.scan_start) <<< XF;
						if (q_data.empty_range) begin
							fin_q   <= '{root: '0, bracket: '0, steps: '0,
								outcome: OUT_NO_SIGN};
							state_q <= B_FINISH;
						end else begin
							state_q <= B_WAIT_LO;
						end
					end
				end
				B_WAIT_LO: begin
					start_q <= ev_done;
					if (ev_done) begin
						slo_q   <= ev_sign;
						x_q     <= XW'(left_p1) <<< XF;
						state_q <= B_WAIT_HI;
					end
				end
				B_WAIT_HI: begin
					start_q <= ev_done && !opposite && (left_p1 < 10'(cfg.scan_end));
					if (ev_done) begin
						if (opposite) begin
							shi_q   <= ev_sign;
							lo_q    <= XW'(left_q) <<< XF;
							hi_q    <= XW'(left_p1) <<< XF;
							steps_q <= '0;
							state_q <= B_BISECT;
						end else if (left_p1 >= 10'(cfg.scan_end)) begin
							fin_q   <= '{root: '0, bracket: '0, steps: '0,
								outcome: OUT_NO_SIGN};
							state_q <= B_FINISH;
						end else begin
							left_q  <= left_p1[7:0];
							slo_q   <= ev_sign;
							x_q     <= XW'(left_p2) <<< XF;
						end
					end
				end
				B_BISECT: begin
					mid_q   <= mid;
					x_q     <= mid;
					start_q <= 1'b1;
					state_q <= B_WAIT_MID;
				end
				B_WAIT_MID: begin
					start_q <= 1'b0;
					if (ev_done) begin
						steps_q       <= steps_nx;
						fin_q.root    <= mid64[31:0];
						fin_q.bracket <= left_q;
						fin_q.steps   <= steps_nx;
						if (ev_conv) begin
							fin_q.outcome <= OUT_CONVERGED;
							state_q       <= B_FINISH;
						end else begin
							if (ev_sign == shi_q) begin
								hi_q <= mid_q;
							end else if (ev_sign == slo_q) begin
								lo_q <= mid_q;
							end
							if (steps_nx >= cfg.iter_limit) begin
								fin_q.outcome <= OUT_LIMIT;
								state_q       <= B_FINISH;
							end else begin
								state_q <= B_BISECT;
							end
						end
					end
				end
				B_FINISH: begin
					start_q <= 1'b0;
					if (res_load) begin
						res     <= fin_q;
						state_q <= B_IDLE;
					end
				end
				default: begin
					start_q <= 1'b0;
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/crb_checker.sv
// Port-level checks on the result channel of the cubic root bisection block,
// bound to the top level. Depends on crb_pkg.
`timescale 1ns / 1ps
module crb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] root_value,
	input logic signed [7:0]  bracket_left,
	input logic [5:0]         step_count,
	input logic [1:0]         outcome
);
	import crb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(root_value)
			&& $stable(step_count) && $stable(outcome))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outcome == OUT_CONVERGED || outcome == OUT_NO_SIGN
			|| outcome == OUT_LIMIT)
		else $error("unknown outcome code");

	a_nosign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_NO_SIGN |->
			root_value == 32'sd0 && bracket_left == 8'sd0 && step_count == 6'd0)
		else $error("no-sign result not cleared");

	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome != OUT_NO_SIGN |-> step_count != 6'd0)
		else $error("bisection result with no steps");

endmodule

bind cubic_root_bisection crb_checker u_crb_checker (.*);

// File: bench/crb_result_checker.sv
// Result checker for the cubic root bisection block: tracks the register
// writes, predicts each result on input transactions and compares outputs.
// Depends on crb_pkg.
`timescale 1ns / 1ps
module crb_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] coef_cubic,
	input  logic signed [31:0] coef_square,
	input  logic signed [31:0] coef_linear,
	input  logic signed [31:0] coef_constant,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] root_value,
	input  logic signed [7:0]  bracket_left,
	input  logic [5:0]         step_count,
	input  logic [1:0]         outcome,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 errors,
	output int                 pending
);
	import crb_pkg::*;

	cfg_t      cfg;
	result_t   roots_due[$];
	coef_set_t coefs;
	result_t   got;

	function automatic void eval_cubic(input coef_set_t k, input logic signed [63:0] x,
			output int sgn, output bit near);
		logic signed [191:0] acc, xw, f, mag, hi_lim, lo_lim;
		xw = x;
		hi_lim = (192'sd1 <<< 127) - 192'sd1;
		lo_lim = -(192'sd1 <<< 127);
		acc = $signed(k.a);
		f = $signed(k.b);
		acc = acc * xw + (f <<< 24);
		f = $signed(k.c);
		acc = acc * xw + (f <<< 48);
		f = $signed(k.d);
		acc = acc * xw + (f <<< 72);
		if (acc > hi_lim) acc = hi_lim;
		else if (acc < lo_lim) acc = lo_lim;
		f = acc >>> 72;
		mag = (f < 0) ? -f : f;
		near = (mag <= $signed({176'd0, cfg.tolerance}));
		sgn = (acc == 0) ? 0 : ((acc < 0) ? -1 : 1);
	endfunction

	function automatic result_t solve_cubic(input coef_set_t k);
		result_t r;
		int left, s_lo, s_hi, s, steps;
		bit near, found;
		logic signed [63:0] lo, hi, mid;
		left = cfg.scan_start;
		found = 0;
		s_lo = 0;
		s_hi = 0;
		while (left < cfg.scan_end) begin
			lo = left;
			hi = left + 1;
			eval_cubic(k, lo <<< 24, s_lo, near);
			eval_cubic(k, hi <<< 24, s_hi, near);
			if (s_lo * s_hi < 0) begin
				found = 1;
				break;
			end
			left++;
		end
		r.root = '0;
		r.bracket = '0;
		r.steps = '0;
		r.outcome = OUT_NO_SIGN;
		if (!found)
			return r;
		lo = left;
		lo = lo <<< 24;
		hi = lo + (64'sd1 <<< 24);
		steps = 0;
		forever begin
			mid = lo + ((hi - lo) >>> 1);
			eval_cubic(k, mid, s, near);
			steps++;
			if (near) begin
				r.outcome = OUT_CONVERGED;
				break;
			end
			if (s == s_hi) hi = mid;
			else if (s == s_lo) lo = mid;
			if (steps >= cfg.iter_limit) begin
				r.outcome = OUT_LIMIT;
				break;
			end
		end
		r.root = mid[31:0];
		r.bracket = left[7:0];
		r.steps = steps[5:0];
		return r;
	endfunction

	assign pending = roots_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.tolerance  <= RST_TOLERANCE;
			cfg.scan_start <= RST_SCAN_START;
			cfg.scan_end   <= RST_SCAN_END;
			cfg.iter_limit <= RST_ITER_LIMIT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TOLERANCE:  cfg.tolerance  <= cfg_data;
				REG_SCAN_START: cfg.scan_start <= cfg_data[7:0];
				REG_SCAN_END:   cfg.scan_end   <= cfg_data[7:0];
				REG_ITER_LIMIT: cfg.iter_limit <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	initial errors = 0;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			coefs.a = coef_cubic;
			coefs.b = coef_square;
			coefs.c = coef_linear;
			coefs.d = coef_constant;
			roots_due.push_back(solve_cubic(coefs));
		end
		if (arst_n && out_valid && !out_stall) begin
			got.root = root_value;
			got.bracket = bracket_left;
			got.steps = step_count;
			got.outcome = outcome_t'(outcome);
			if (roots_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result root=%h left=%0d steps=%0d out=%0d",
						$realtime, root_value, bracket_left, step_count, outcome);
			end else begin
				result_t want;
				want = roots_due.pop_front();
				if (want.root !== got.root || want.bracket !== got.bracket ||
						want.steps !== got.steps || want.outcome !== got.outcome) begin
					errors++;
					if (errors <= 10)
						$display({"%0t: mismatch exp root=%h left=%0d steps=%0d out=%0d",
							" got root=%h left=%0d steps=%0d out=%0d"}, $realtime,
							want.root, want.bracket, want.steps, want.outcome,
							got.root, got.bracket, got.steps, got.outcome);
				end
			end
		end
	end

endmodule

// File: bench/cubic_root_bisection_tb.sv
// Testbench top for the cubic root bisection block: clock, reset, stimulus,
// register phases and verdict. Depends on crb_pkg, the block and crb_result_checker.
`timescale 1ns / 1ps
module cubic_root_bisection_tb;
	import crb_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [31:0] coef_cubic = 0;
	logic signed [31:0] coef_square = 0;
	logic signed [31:0] coef_linear = 0;
	logic signed [31:0] coef_constant = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] root_value;
	logic signed [7:0]  bracket_left;
	logic [5:0]         step_count;
	logic [1:0]         outcome;
	logic               cfg_write = 0;
	logic [1:0]         cfg_index = REG_TOLERANCE;
	logic [15:0]        cfg_data = 0;
	int                 errors;
	int                 pending;
	logic               in_fired;
	bit                 squeeze = 0;
	int                 burst_left = 0;
	int                 lo_int = -100;
	int                 hi_int = 100;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	cubic_root_bisection dut (.*);

	crb_result_checker chk (.*);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fired <= 0;
		end else begin
			in_fired <= in_valid && !in_stall;
		end
	end

	task automatic send_item(input logic [31:0] a, b, c, d);
		if (burst_left == 0) begin
			in_valid = 0;
			repeat ($urandom_range(0, 30)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid = 1;
		coef_cubic = a;
		coef_square = b;
		coef_linear = c;
		coef_constant = d;
		do @(negedge clk); while (!in_fired);
		burst_left--;
	endtask

	task automatic drain();
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_regs(input logic [15:0] tol, input logic [7:0] first,
			input logic [7:0] last, input logic [5:0] lim);
		drain();
		cfg_write = 1;
		cfg_index = REG_TOLERANCE;
		cfg_data = tol;
		@(negedge clk);
		cfg_index = REG_SCAN_START;
		cfg_data = {8'($urandom), first};
		@(negedge clk);
		cfg_index = REG_SCAN_END;
		cfg_data = {8'($urandom), last};
		@(negedge clk);
		cfg_index = REG_ITER_LIMIT;
		cfg_data = {10'($urandom), lim};
		@(negedge clk);
		cfg_write = 0;
		lo_int = $signed(first);
		hi_int = $signed(last);
	endtask

	task automatic send_shaped();
		longint k, r, q, kr;
		int span;
		k = $urandom_range(1, 131072);
		if ($urandom_range(0, 1)) k = -k;
		span = (hi_int > lo_int) ? hi_int - lo_int : 1;
		r = longint'($urandom_range(0, span * 65536)) + longint'(lo_int) * 65536;
		q = $urandom_range(0, 262144);
		kr = (k * r) >>> 16;
		send_item(32'(k), 32'(-kr), 32'((k * q) >>> 16), 32'(-((kr * q) >>> 16)));
	endtask

	initial begin
		int sent, n, first, span;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_item(0, 0, 0, 0);
		send_item(0, 0, 32'sd65536, -32'sd32768);
		send_item(32'sd65536, 0, 0, -32'sd131072);
		send_item(-32'sd65536, 0, 0, 32'sd655360);
		send_item(0, 32'sd65536, 0, -32'sd65536);
		send_item(0, 32'sd65536, 0, -32'sd131072);
		send_item(0, 0, 0, 32'sd12345);
		send_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		send_item(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);

		set_regs(16'hFFFF, 8'h80, 8'h7F, 6'd63);
		send_item(0, 0, 32'sd65536, -32'sd8303411);
		send_item(32'sd65536, 0, 0, -32'sd131072);
		send_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);

		set_regs(16'd1, 8'd126, 8'd127, 6'd0);
		send_item(0, 0, 32'sd65536, -32'sd8290304);
		send_item(0, 0, 32'sd65536, -32'sd8303411);

		set_regs(16'd1, 8'd1, 8'd2, 6'd63);
		send_item(32'sd65536, 0, 0, -32'sd131072);
		send_item(0, 32'sd65536, 0, -32'sd131072);
		send_item(0, -32'sd65536, 0, 32'sd131072);

		set_regs(16'd66, 8'd127, 8'h80, 6'd40);
		send_item(0, 0, 32'sd65536, -32'sd32768);
		set_regs(16'd500, 8'd5, 8'd5, 6'd20);
		send_item(0, 0, 32'sd65536, -32'sd360448);

		sent = 0;
		while (sent < 450) begin
			if ($urandom_range(0, 9) == 0) begin
				first = -128 + $urandom_range(0, 10);
				span = 255;
				n = 3;
			end else begin
				first = int'($urandom_range(0, 12)) - 8;
				span = $urandom_range(0, 10);
				n = $urandom_range(20, 50);
			end
			if (first + span > 127) span = 127 - first;
			case ($urandom_range(0, 3))
				0: set_regs(16'd1, 8'(first), 8'(first + span), 6'($urandom_range(0, 63)));
				1: set_regs(16'hFFFF, 8'(first), 8'(first + span),
					6'($urandom_range(1, 63)));
				default: set_regs(16'($urandom_range(1, 65535)), 8'(first),
					8'(first + span), 6'($urandom_range(1, 63)));
			endcase
			if (n >= 20) squeeze = 1;
			while (n > 0 && sent < 450) begin
				case ($urandom_range(0, 19))
					0, 1, 2: send_item($urandom, $urandom, $urandom, $urandom);
					3, 4, 5, 6, 7: send_item($signed($urandom_range(0, 1048575)) - 524288,
						$signed($urandom_range(0, 1048575)) - 524288,
						$signed($urandom_range(0, 1048575)) - 524288,
						$signed($urandom_range(0, 1048575)) - 524288);
					default: send_shaped();
				endcase
				sent++;
				n--;
			end
		end

		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int mode, left_in_mode;
		bit squeezed;
		mode = 0;
		left_in_mode = 0;
		squeezed = 0;
		forever begin
			@(negedge clk);
			if (squeeze && !squeezed) begin
				squeezed = 1;
				out_stall = 1;
				repeat (20000) @(negedge clk);
			end
			if (left_in_mode == 0) begin
				mode = $urandom_range(0, 2);
				left_in_mode = $urandom_range(50, 400);
			end
			left_in_mode--;
			case (mode)
				0: out_stall = 0;
				1: out_stall = ($urandom_range(0, 9) < 3);
				default: out_stall = ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	initial begin
		#100_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
